// ----- rtl/core/circular_source_ray_generator_core_macros.svh -----
// assertion macros for the circular source ray generator
`ifndef CIRCULAR_SOURCE_RAY_GENERATOR_CORE_MACROS_SVH
`define CIRCULAR_SOURCE_RAY_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CSRG_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CSRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/csrg_pkg.sv -----
// shared constants, tables and types of the circular source ray generator
package csrg_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int MAX_RAYS      = 64;
  localparam int CORDIC_STAGES = 16;

  localparam int IDX_W   = 18;
  localparam int PTS_W   = 13;
  localparam int RPP_W   = 7;
  localparam int TOTAL_W = 19;
  localparam int POINT_W = $clog2(MAX_POINTS);
  localparam int RAY_W   = $clog2(MAX_RAYS);

  // restoring divider: quotient bits, numerator and divisor widths
  localparam int DIV_QW = 32;
  localparam int DIV_DW = 13;
  localparam int DIV_NW = DIV_QW + DIV_DW;

  localparam int CW          = 34;
  localparam int CORDIC_LAT  = CORDIC_STAGES + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAYS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_RATE = 3'd5;

  // atan(2^-i) in binary turns, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             err;
  } csrg_item_t;

  typedef struct packed {
    logic [31:0]        origin_x;
    logic [31:0]        origin_y;
    logic [15:0]        dir_x;
    logic [15:0]        dir_y;
    logic [31:0]        brightness;
    logic [TOTAL_W-1:0] total_rays;
    logic               index_error;
  } csrg_result_t;

endpackage

// ----- rtl/core/csrg_front.sv -----
// input stage: takes index beats and flags those out of range
module csrg_front import csrg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   in_idx,
  input  logic [TOTAL_W-1:0] total,
  input  logic               q_full,
  output logic               push,
  output csrg_item_t         push_item
);

  logic             fvalid;
  logic [IDX_W-1:0] fidx;

  assign in_ready      = !fvalid || !q_full;
  assign push          = fvalid && !q_full;
  assign push_item.idx = fidx;
  assign push_item.err = {1'b0, fidx} >= total;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (in_ready) begin
      fvalid <= in_valid;
    end
    if (in_ready && in_valid) begin
      fidx <= in_idx;
    end
  end

endmodule

// ----- rtl/core/csrg_queue.sv -----
// short fifo between front and back
module csrg_queue import csrg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  csrg_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output csrg_item_t head
);

  csrg_item_t          mem [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/csrg_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module csrg_div import csrg_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo,
  output logic [DIV_DW-1:0] rem
);

  // numerator must stay below den * 2^DIV_QW
  logic [DIV_DW-1:0] r_q [1:DIV_QW];
  logic [DIV_QW-1:0] lo_q [1:DIV_QW];
  logic [DIV_QW-1:0] q_q [1:DIV_QW];
  logic [DIV_DW-1:0] d_q [1:DIV_QW];

  for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
    logic [DIV_DW-1:0] r_in, d_in;
    logic [DIV_QW-1:0] lo_in, q_in;
    logic [DIV_DW:0]   t, diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign r_in  = num[DIV_NW-1:DIV_QW];
      assign lo_in = num[DIV_QW-1:0];
      assign q_in  = '0;
      assign d_in  = den;
    end else begin : g_rest
      assign r_in  = r_q[i];
      assign lo_in = lo_q[i];
      assign q_in  = q_q[i];
      assign d_in  = d_q[i];
    end

    assign t    = {r_in, lo_in[DIV_QW-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[i+1]  <= ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
        lo_q[i+1] <= {lo_in[DIV_QW-2:0], 1'b0};
        q_q[i+1]  <= {q_in[DIV_QW-2:0], ge};
        d_q[i+1]  <= d_in;
      end
    end
  end

  assign quo = q_q[DIV_QW];
  assign rem = r_q[DIV_QW];

endmodule

// ----- rtl/core/csrg_cordic.sv -----
// pipelined cordic rotation: cos and sin of a binary-turn angle, q2.30
module csrg_cordic import csrg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ang,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam logic signed [CW-1:0] QUARTER = CW'(64'd1073741824);
  localparam logic signed [CW-1:0] HALF    = CW'(64'd2147483648);
  localparam logic signed [CW-1:0] X0      = CW'(64'd652032874);

  logic signed [CW-1:0] x [0:CORDIC_STAGES];
  logic signed [CW-1:0] y [0:CORDIC_STAGES];
  logic signed [CW-1:0] z [0:CORDIC_STAGES];
  logic                 neg [0:CORDIC_STAGES];
  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] xo, yo;

  assign z_in = CW'($signed(ang));

  // quadrant fold: beyond a quarter turn, rotate by a half turn and negate later
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= X0;
      y[0] <= '0;
      if (z_in > QUARTER) begin
        z[0]   <= z_in - HALF;
        neg[0] <= 1'b1;
      end else if (z_in < -QUARTER) begin
        z[0]   <= z_in + HALF;
        neg[0] <= 1'b1;
      end else begin
        z[0]   <= z_in;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy, at;
    assign dx = x[i] >>> i;
    assign dy = y[i] >>> i;
    assign at = CW'(ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CW-1]) begin
          x[i+1] <= x[i] - dy;
          y[i+1] <= y[i] + dx;
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + dy;
          y[i+1] <= y[i] - dx;
          z[i+1] <= z[i] + at;
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  assign xo    = neg[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
  assign yo    = neg[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
  assign cos_o = xo[31:0];
  assign sin_o = yo[31:0];

endmodule

// ----- rtl/core/csrg_back.sv -----
// back pipeline: index split, angle division, cordic, scaling, output register
module csrg_back import csrg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  csrg_item_t         q_head,
  output logic               pop,
  input  logic [PTS_W-1:0]   pts,
  input  logic [RPP_W-1:0]   rpp,
  input  logic [TOTAL_W-1:0] total,
  input  logic [31:0]        center_x,
  input  logic [31:0]        center_y,
  input  logic [30:0]        radius,
  input  logic [31:0]        rate,
  output logic               out_valid,
  input  logic               out_ready,
  output csrg_result_t       result
);

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && q_valid;

  function automatic logic [15:0] to_q14(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [16:0] r;
    t = {v[31], v} + 33'sd32768;
    r = t[32:16];
    if (r > 17'sd16384) begin
      return 16'sd16384;
    end else if (r < -17'sd16384) begin
      return -16'sd16384;
    end
    return r[15:0];
  endfunction

  function automatic logic [31:0] place(input logic signed [31:0] c,
                                        input logic signed [63:0] p);
    logic signed [64:0] t;
    logic signed [34:0] v;
    t = {p[63], p} + 65'sd536870912;
    v = $signed(t[64:30]) + 35'($signed(c));
    if (v > 35'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // split the index: point and ray within point
  logic [DIV_QW-1:0] qa;
  logic [DIV_DW-1:0] ra;
  logic [DIV_QW-1:0] a_v, a_e;

  csrg_div u_div_split (
    .clk (clk),
    .en  (en),
    .num (DIV_NW'(q_head.idx)),
    .den (DIV_DW'(rpp)),
    .quo (qa),
    .rem (ra)
  );

  // normal and fan offset divisions
  logic [POINT_W-1:0] point;
  logic [RAY_W-1:0]   ray;
  logic [RPP_W-1:0]   d, mag;
  logic signed [8:0]  m, m_abs;
  logic [DIV_NW-1:0]  num_n, num_o;
  logic [DIV_DW-1:0]  den_o;
  logic [DIV_QW-1:0]  normal, qo;
  logic [DIV_QW-1:0]  b_v, b_e, b_n;

  assign point = qa[POINT_W-1:0];
  assign ray   = ra[RAY_W-1:0];
  assign d     = rpp - 1'b1;
  assign m     = $signed({2'b00, ray, 1'b0}) - $signed({2'b00, d});
  assign m_abs = m[8] ? -m : m;
  assign mag   = m_abs[RPP_W-1:0];
  assign num_n = (DIV_NW'(point) << DIV_QW) | DIV_NW'(pts >> 1);
  assign num_o = (DIV_NW'(mag) << 30) | DIV_NW'(d >> 1);
  assign den_o = (rpp == RPP_W'(1)) ? DIV_DW'(1) : DIV_DW'(d);

  csrg_div u_div_normal (
    .clk (clk),
    .en  (en),
    .num (num_n),
    .den (DIV_DW'(pts)),
    .quo (normal),
    .rem ()
  );

  csrg_div u_div_offset (
    .clk (clk),
    .en  (en),
    .num (num_o),
    .den (den_o),
    .quo (qo),
    .rem ()
  );

  // three rotations: emitter point, ray direction, fan offset
  logic [31:0]        offset, angle;
  logic signed [31:0] c_n, s_n, c_d, s_d, c_o;
  logic [CORDIC_LAT-1:0] c_v, c_e, c_z;

  assign offset = b_n[DIV_QW-1] ? (32'd0 - qo) : qo;
  assign angle  = normal + offset;

  csrg_cordic u_cordic_normal (
    .clk (clk), .en (en), .ang (normal), .cos_o (c_n), .sin_o (s_n)
  );

  csrg_cordic u_cordic_dir (
    .clk (clk), .en (en), .ang (angle), .cos_o (c_d), .sin_o (s_d)
  );

  csrg_cordic u_cordic_offset (
    .clk (clk), .en (en), .ang (offset), .cos_o (c_o), .sin_o ()
  );

  // product stage
  logic signed [63:0] px, py;
  logic [62:0]        pb;
  logic [15:0]        pdx, pdy;
  logic               p_v, p_e, p_z;
  logic [63:0]        bt;

  assign bt = {1'b0, pb} + 64'd536870912;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= '0;
      b_v       <= '0;
      c_v       <= '0;
      p_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v       <= {a_v[DIV_QW-2:0], pop};
      b_v       <= {b_v[DIV_QW-2:0], a_v[DIV_QW-1]};
      c_v       <= {c_v[CORDIC_LAT-2:0], b_v[DIV_QW-1]};
      p_v       <= c_v[CORDIC_LAT-1];
      out_valid <= p_v;
    end
    if (en) begin
      a_e <= {a_e[DIV_QW-2:0], q_head.err};
      b_e <= {b_e[DIV_QW-2:0], a_e[DIV_QW-1]};
      b_n <= {b_n[DIV_QW-2:0], m[8]};
      c_e <= {c_e[CORDIC_LAT-2:0], b_e[DIV_QW-1]};
      c_z <= {c_z[CORDIC_LAT-2:0], qo == '0};

      px  <= $signed({1'b0, radius}) * c_n;
      py  <= $signed({1'b0, radius}) * s_n;
      pb  <= rate * (c_o[31] ? 31'd0 : c_o[30:0]);
      pdx <= to_q14(c_d);
      pdy <= to_q14(s_d);
      p_e <= c_e[CORDIC_LAT-1];
      p_z <= c_z[CORDIC_LAT-1];

      result.total_rays  <= total;
      result.index_error <= p_e;
      if (p_e) begin
        result.origin_x   <= '0;
        result.origin_y   <= '0;
        result.dir_x      <= '0;
        result.dir_y      <= '0;
        result.brightness <= '0;
      end else begin
        result.origin_x   <= place(center_x, px);
        result.origin_y   <= place(center_y, py);
        result.dir_x      <= pdx;
        result.dir_y      <= pdy;
        if (p_z) begin
          result.brightness <= rate;
        end else if (|bt[63:62]) begin
          result.brightness <= 32'hFFFFFFFF;
        end else begin
          result.brightness <= bt[61:30];
        end
      end
    end
  end

endmodule

// ----- rtl/core/circular_source_ray_generator_core.sv -----
// top level of the circular source ray generator: config registers, front, queue, back
// path: an accepted index beat passes the front register, the queue, the index split divider, the angle
// dividers, the cordics, the product register and the output register before its result beat is valid
// throughput: one beat per cycle; every stage is pipelined and stalls only on m_tready
// reset: rst is synchronous; it empties front, queue and pipeline and restores the
// register defaults (centre 0, radius 1.0, one point, one ray, send rate 1.0)
`include "circular_source_ray_generator_core_macros.svh"

module circular_source_ray_generator_core import csrg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // index beats
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // ray_num[17:0], zero pad
  // result beats
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // origin_x[31:0], origin_y[63:32], dir_x[79:64], dir_y[95:80],
  // brightness[127:96], total_rays[146:128], zero pad
  output logic [151:0]         m_tdata,
  output logic                 m_tuser    // index_error
);

  // config registers
  logic [31:0]      center_x, center_y, send_rate;
  logic [30:0]      circle_radius;
  logic [PTS_W-1:0] point_count;
  logic [RPP_W-1:0] rays_per_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      circle_radius  <= 31'd65536;
      point_count    <= PTS_W'(1);
      rays_per_point <= RPP_W'(1);
      send_rate      <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:  center_x       <= cfg_data;
        REG_CENTER_Y:  center_y       <= cfg_data;
        REG_RADIUS:    circle_radius  <= cfg_data[30:0];
        REG_POINTS:    point_count    <= cfg_data[PTS_W-1:0];
        REG_RAYS:      rays_per_point <= cfg_data[RPP_W-1:0];
        REG_SEND_RATE: send_rate      <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero counts act as one, oversize counts as the maximum
  logic [PTS_W-1:0]   pts_eff;
  logic [RPP_W-1:0]   rpp_eff;
  logic [TOTAL_W-1:0] total;

  always_comb begin
    priority if (point_count == '0) begin
      pts_eff = PTS_W'(1);
    end else if (point_count > PTS_W'(MAX_POINTS)) begin
      pts_eff = PTS_W'(MAX_POINTS);
    end else begin
      pts_eff = point_count;
    end
    priority if (rays_per_point == '0) begin
      rpp_eff = RPP_W'(1);
    end else if (rays_per_point > RPP_W'(MAX_RAYS)) begin
      rpp_eff = RPP_W'(MAX_RAYS);
    end else begin
      rpp_eff = rays_per_point;
    end
  end

  assign total = TOTAL_W'(pts_eff) * TOTAL_W'(rpp_eff);

  // front: accept and range-check
  logic       q_push, q_full, q_pop, q_valid;
  csrg_item_t q_in, q_head;

  csrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_idx    (s_tdata[IDX_W-1:0]),
    .total     (total),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_in)
  );

  csrg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: geometry pipeline and output register
  csrg_result_t res;

  csrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (q_pop),
    .pts       (pts_eff),
    .rpp       (rpp_eff),
    .total     (total),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (circle_radius),
    .rate      (send_rate),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (res)
  );

  assign m_tdata = {5'd0, res.total_rays, res.brightness, res.dir_y, res.dir_x,
                    res.origin_y, res.origin_x};
  assign m_tuser = res.index_error;

  // checks
  `CSRG_ASSERT(a_err_zero, m_tvalid && m_tuser, m_tdata[127:0] == '0, "error beat carries data")
  `CSRG_ASSERT(a_dir_range, m_tvalid && !m_tuser, ($signed(m_tdata[79:64]) <= 16'sd16384) && ($signed(m_tdata[79:64]) >= -16'sd16384), "dir_x out of range")
  `CSRG_ASSERT(a_total, m_tvalid, m_tdata[146:128] == total, "total_rays mismatch")
  `CSRG_ASSERT_NEXT(a_queue_full, q_full && !q_pop, !q_push, "push into full queue")

endmodule

// ----- tb/circular_source_ray_generator_core_checker.sv -----
// result checker of the circular source ray generator: mirrors the registers, predicts, compares
module circular_source_ray_generator_core_checker import csrg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [151:0]         m_tdata,
  input  logic                 m_tuser,
  output int                   pending,
  output int                   fails
);

  localparam longint GAIN_X0 = 64'sd652032874;
  localparam longint QUARTER = 64'sd1073741824;
  localparam longint HALF    = 64'sd2147483648;

  typedef struct {
    logic [31:0]        origin_x;
    logic [31:0]        origin_y;
    logic [15:0]        dir_x;
    logic [15:0]        dir_y;
    logic [31:0]        brightness;
    logic [TOTAL_W-1:0] total_rays;
    logic               index_error;
  } ray_t;

  ray_t rays_due[$];

  // register mirror
  longint          centre_x, centre_y;
  longint unsigned radius, points, fan_rays, rate;

  // cos and sin of a binary-turn angle in Q2.30
  task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit neg;
    z = longint'($signed(ang));
    neg = 0;
    x = GAIN_X0;
    y = 0;
    if (z > QUARTER) begin
      z -= HALF;
      neg = 1;
    end else if (z < -QUARTER) begin
      z += HALF;
      neg = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic logic [15:0] q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic logic [31:0] on_circle(input longint centre, input longint t);
    longint off, v;
    off = (longint'(radius) * t + (64'sd1 <<< 29)) >>> 30;
    v = centre + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_ray(input logic [IDX_W-1:0] idx, output ray_t r);
    longint unsigned pts, rpp, total, point, ray, d, mag, q, b;
    longint m, c, s;
    logic [31:0] normal, offset;
    pts = points;
    rpp = fan_rays;
    if (pts < 1) pts = 1;
    if (pts > MAX_POINTS) pts = MAX_POINTS;
    if (rpp < 1) rpp = 1;
    if (rpp > MAX_RAYS) rpp = MAX_RAYS;
    total = pts * rpp;
    r.total_rays = total[TOTAL_W-1:0];
    r.origin_x = '0; r.origin_y = '0; r.dir_x = '0; r.dir_y = '0; r.brightness = '0;
    r.index_error = (idx >= total);
    if (!r.index_error) begin
      point = idx / rpp;
      ray = idx % rpp;
      normal = 32'(((point << 32) + pts / 2) / pts);
      offset = '0;
      if (rpp > 1) begin
        d = rpp - 1;
        m = longint'(2 * ray) - longint'(d);
        mag = longint'(m < 0 ? -m : m) << 30;
        q = (mag + d / 2) / d;
        offset = m < 0 ? 32'(-q) : 32'(q);
      end
      sincos(normal, c, s);
      r.origin_x = on_circle(centre_x, c);
      r.origin_y = on_circle(centre_y, s);
      sincos(normal + offset, c, s);
      r.dir_x = q14(c);
      r.dir_y = q14(s);
      // a zero offset gives the full send rate
      if (offset == 0) begin
        r.brightness = rate[31:0];
      end else begin
        sincos(offset, c, s);
        if (c < 0) c = 0;
        b = (rate * longint'(c) + (64'd1 << 29)) >> 30;
        r.brightness = b > 64'hFFFFFFFF ? 32'hFFFFFFFF : b[31:0];
      end
    end
  endtask

  task automatic mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;
  assign pending = rays_due.size();

  always @(posedge clk) begin
    ray_t want, got;
    if (rst) begin
      centre_x <= 0; centre_y <= 0; radius <= 65536;
      points <= 1; fan_rays <= 1; rate <= 65536;
      rays_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X:  centre_x <= longint'($signed(cfg_data));
          REG_CENTER_Y:  centre_y <= longint'($signed(cfg_data));
          REG_RADIUS:    radius   <= cfg_data[30:0];
          REG_POINTS:    points   <= cfg_data[PTS_W-1:0];
          REG_RAYS:      fan_rays <= cfg_data[RPP_W-1:0];
          REG_SEND_RATE: rate     <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.origin_x    = m_tdata[31:0];
        got.origin_y    = m_tdata[63:32];
        got.dir_x       = m_tdata[79:64];
        got.dir_y       = m_tdata[95:80];
        got.brightness  = m_tdata[127:96];
        got.total_rays  = m_tdata[146:128];
        got.index_error = m_tuser;
        if (rays_due.size() == 0) begin
          mismatch("unexpected result beat", m_tdata[63:0], 64'd0);
        end else begin
          want = rays_due.pop_front();
          if (got.origin_x != want.origin_x) mismatch("origin_x", got.origin_x, want.origin_x);
          if (got.origin_y != want.origin_y) mismatch("origin_y", got.origin_y, want.origin_y);
          if (got.dir_x != want.dir_x) mismatch("dir_x", got.dir_x, want.dir_x);
          if (got.dir_y != want.dir_y) mismatch("dir_y", got.dir_y, want.dir_y);
          if (got.brightness != want.brightness)
            mismatch("brightness", got.brightness, want.brightness);
          if (got.total_rays != want.total_rays)
            mismatch("total_rays", got.total_rays, want.total_rays);
          if (got.index_error != want.index_error)
            mismatch("index_error", got.index_error, want.index_error);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_ray(s_tdata[IDX_W-1:0], want);
        rays_due.push_back(want);
      end
    end
  end

endmodule

// ----- tb/circular_source_ray_generator_core_tb.sv -----
// stimulus and verdict for the circular source ray generator
module circular_source_ray_generator_core_tb import csrg_pkg::*;;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;  // ray_num[17:0], zero pad
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [151:0]         m_tdata;       // origin_x, origin_y, dir_x, dir_y, brightness, total_rays
  logic                 m_tuser;       // index_error

  int pending, fails;
  int snd_idle, rcv_idle;     // idle chance in percent for each side
  int hold_req, hold_seen;    // long receiver stall request, toggled by stimulus
  int hold_left;
  int beats_sent, settings;

  always #5 clk = ~clk;

  circular_source_ray_generator_core dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  circular_source_ray_generator_core_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .pending, .fails
  );

  // receiver: random stalls, plus a long hold-off on request so the pipe backs up
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // generous run limit
  initial begin
    #3000000;
    $display("run timed out");
    $display("circular_source_ray_generator_core_tb: FAIL");
    $finish;
  end

  // one index beat; valid stays high across back-to-back beats
  task automatic send_index(input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'd0, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // stop sending and wait until every result is in, then let the pipe go quiet
  task automatic drain;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // write all six registers while the block is idle
  task automatic load_regs(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] rad,
                           input logic [31:0] pts, input logic [31:0] rays,
                           input logic [31:0] rate);
    logic [31:0] vals [6];
    vals = '{cx, cy, rad, pts, rays, rate};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    settings++;
  endtask

  function automatic int eff_total(input logic [31:0] pts, input logic [31:0] rays);
    int p, r;
    p = pts[PTS_W-1:0];
    r = rays[RPP_W-1:0];
    if (p < 1) p = 1;
    if (p > MAX_POINTS) p = MAX_POINTS;
    if (r < 1) r = 1;
    if (r > MAX_RAYS) r = MAX_RAYS;
    return p * r;
  endfunction

  // mostly in-range indices, some just past the end, some anywhere
  function automatic logic [IDX_W-1:0] pick_index(input int total);
    int k;
    k = $urandom_range(99);
    if (k < 70) return IDX_W'($urandom_range(total - 1, 0));
    if (k < 85) return IDX_W'(total + $urandom_range(3));
    return IDX_W'($urandom);
  endfunction

  initial begin
    logic [31:0] cx, cy, rad, pts, rays, rate;
    int total, k;
    snd_idle = 34;
    rcv_idle = 54;
    hold_req = 0;
    beats_sent = 0;
    settings = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults after reset: one point, one ray
    send_index(0);
    send_index(1);
    send_index(IDX_W'(262143));

    // largest counts, saturating origin, full-scale rate
    load_regs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 4096, 64, 32'hFFFFFFFF);
    send_index(0);
    send_index(31);
    send_index(32);
    send_index(63);
    send_index(64);
    send_index(IDX_W'(131072));
    send_index(IDX_W'(262142));
    send_index(IDX_W'(262143));

    // zero counts act as one; zero radius and rate
    load_regs(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0);
    send_index(0);
    send_index(1);
    send_index(IDX_W'(170000));

    // counts above the maximum clamp; two rays put offsets at the fan edges
    load_regs(32'h00010000, 32'hFFFF0000, 32'h00030000, 8191, 127, 32'h00020000);
    send_index(0);
    send_index(IDX_W'(262143));
    load_regs(32'h00000000, 32'h00000000, 32'h00010000, 3, 2, 32'h00010000);
    for (int i = 0; i < 7; i++) send_index(IDX_W'(i));

    // random phases over fresh register settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        snd_idle = 54; rcv_idle = 34;
      end else if (ph == 6) begin
        snd_idle = 0; rcv_idle = 0;
      end
      k = $urandom_range(9);
      pts = k < 8 ? $urandom_range(12, 1) : (k == 8 ? 0 : $urandom_range(8191, 4097));
      k = $urandom_range(9);
      rays = k < 8 ? $urandom_range(9, 1) : (k == 8 ? 0 : $urandom_range(127, 65));
      cx = $urandom;
      cy = $urandom;
      rad = $urandom_range(1) ? ($urandom & 32'h7FFFFFFF) : $urandom_range(32'h00100000);
      rate = $urandom;
      load_regs(cx, cy, rad, pts, rays, rate);
      total = eff_total(pts, rays);
      if (ph == 1 || ph == 7) hold_req <= hold_req + 1;
      for (int n = 0; n < 90; n++) begin
        // one pause mid-phase until the pipe has emptied
        if (ph == 4 && n == 45) begin
          s_tvalid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_index(pick_index(total));
      end
    end

    drain();
    $display("covered %0d index beats over %0d register settings, with idling, long stalls",
             beats_sent, settings + 1);
    $display("and saturating, clamped, zero-count and out-of-range cases");
    if (fails == 0) begin
      $display("circular_source_ray_generator_core_tb: PASS");
    end else begin
      $display("circular_source_ray_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
